/* hdl/assert_macros.svh */
// Assertion helper macros for the routing table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, reset masks it.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/lrt_pkg.sv */
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and codes of the longest-prefix-match route table.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam logic [2:0] OP_ADD_V4 = 3'd0;
  localparam logic [2:0] OP_ADD_V6 = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_LOOK_V4 = 3'd3;
  localparam logic [2:0] OP_LOOK_V6 = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  localparam int ENTRY_W = 1 + 128 + 128 + 129 + 32 + 2;  // without iface, rank

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        gw_present;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [7:0]  iface_id;
    logic [31:0] route_metric;
    logic [1:0]  route_origin;
    logic [3:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [63:0] found_mask_hi;
    logic [63:0] found_mask_lo;
    logic        found_gw_present;
    logic [63:0] found_gw_hi;
    logic [63:0] found_gw_lo;
    logic [7:0]  found_iface;
    logic [31:0] found_metric;
    logic [1:0]  found_origin;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // capture request
    logic scan_clr;    // clear scan state, point at entry 0
    logic scan_step;   // evaluate fetched entry, advance
    logic rank_step;   // rank fix-up for remove, advance
    logic do_add;      // write entry at free slot
    logic do_remove;   // clear valid of target slot
    logic emit;        // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       scan_last;
  } sts_t;

endpackage

/* hdl/lrt_ram.sv */
// ----------------------------------------------------------------------------
// lrt_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/lrt_datapath.sv */
// ----------------------------------------------------------------------------
// lrt_datapath
// Request register, entry storage, scan compare/select and result register.
// ----------------------------------------------------------------------------
module lrt_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int IFACE_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  lrt_pkg::req_t req,
  input  lrt_pkg::cmd_t cmd,
  input  logic          reread,
  output lrt_pkg::sts_t sts,
  output lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = ENTRY_W + IFACE_ID_BITS + IW;  // stored word

  req_t r;
  logic [TABLE_DEPTH-1:0] valid;
  logic [IW-1:0] rank [TABLE_DEPTH];
  logic [CW-1:0] count;
  logic [IW-1:0] ptr;         // address presented to RAM
  logic [IW-1:0] cur;         // entry whose data is on rdata
  logic          cur_ok;      // rdata holds a fetched entry
  logic          have;
  logic [IW-1:0] best;
  logic [7:0]    best_len;
  logic [31:0]   best_metric;
  logic [IW-1:0] best_rank;

  // add-side conditioning
  logic        is_v6_add;
  logic [127:0] a_in, m_in, g_in;
  logic [IW-1:0] free_slot;
  logic          have_free;
  logic [RW-1:0] wword, rword;
  logic [IFACE_ID_BITS-1:0] iface_k;  // interface id kept to IFACE_ID_BITS
  logic [IW-1:0] tgt;                 // remove target slot

  assign iface_k = IFACE_ID_BITS'({{IFACE_ID_BITS{1'b0}}, r.iface_id});
  assign tgt = IW'({{IW{1'b0}}, r.slot_in});

  always_comb begin
    is_v6_add = (r.opcode == OP_ADD_V6);
    a_in = is_v6_add ? {r.addr_hi, r.addr_lo} : {96'd0, r.addr_lo[31:0]};
    m_in = is_v6_add ? {r.mask_hi, r.mask_lo} : {96'd0, r.mask_lo[31:0]};
    g_in = !r.gw_present ? 128'd0 :
           (is_v6_add ? {r.gw_hi, r.gw_lo} : {96'd0, r.gw_lo[31:0]});
    wword = {is_v6_add, a_in & m_in, m_in, r.gw_present, g_in,
             r.route_metric, r.route_origin, iface_k,
             count[IW-1:0]};
    free_slot = '0;
    have_free = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IW'(i);
        have_free = 1'b1;
      end
    end
  end

  lrt_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.do_add && have_free),
    .waddr (free_slot),
    .wdata (wword),
    .raddr (ptr),
    .rdata (rword)
  );

  // fields of the fetched entry
  logic          e_v6, e_gwp;
  logic [127:0]  e_dest, e_mask, e_gw;
  logic [31:0]   e_metric;
  logic [1:0]    e_origin;
  logic [IFACE_ID_BITS-1:0] e_iface;
  logic [IW-1:0] e_rank_unused;
  logic [127:0]  look_a;
  logic          look_v6, hit, better;
  logic [7:0]    len;

  assign {e_v6, e_dest, e_mask, e_gwp, e_gw, e_metric, e_origin, e_iface,
          e_rank_unused} = rword;

  always_comb begin
    look_v6 = (r.opcode == OP_LOOK_V6);
    look_a = look_v6 ? {r.addr_hi, r.addr_lo} : {96'd0, r.addr_lo[31:0]};
    len = 8'($countones(e_mask));
    hit = cur_ok && valid[cur] && (e_v6 == look_v6) && ((look_a & e_mask) == e_dest);
    better = !have || (len > best_len) ||
             (len == best_len && (e_metric < best_metric ||
              (e_metric == best_metric && rank[cur] < best_rank)));
  end

  assign sts.opcode = r.opcode;
  assign sts.scan_last = cur_ok && (cur == IW'(TABLE_DEPTH - 1));

  logic slot_ok;
  assign slot_ok = ({28'd0, r.slot_in} < 32'(TABLE_DEPTH)) && valid[tgt];

  always_ff @(posedge clk) begin
    if (cmd.load_req) r <= req;
    if (cmd.scan_clr) begin
      ptr <= '0;
      cur_ok <= 1'b0;
      have <= 1'b0;
    end else if (cmd.scan_step || cmd.rank_step) begin
      ptr <= ptr + 1'b1;
      cur <= ptr;
      cur_ok <= 1'b1;
    end else if (reread) begin
      ptr <= best;
    end
    if (cmd.scan_step && hit && better) begin
      have <= 1'b1;
      best <= cur;
      best_len <= len;
      best_metric <= e_metric;
      best_rank <= rank[cur];
    end
    if (cmd.do_add && have_free) rank[free_slot] <= count[IW-1:0];
    // last scan cycle has walked past the top entry; skip it
    if (cmd.rank_step && !sts.scan_last && slot_ok && valid[ptr] &&
        rank[ptr] > rank[tgt])
      rank[ptr] <= rank[ptr] - 1'b1;
    if (cmd.emit) begin
      rsp <= '0;
      unique case (r.opcode)
        OP_ADD_V4, OP_ADD_V6: begin
          if (!have_free) rsp.status <= ST_FULL;
          else begin
            rsp.status <= ST_OK;
            rsp.slot_out <= 4'(free_slot);
            {rsp.dest_hi, rsp.dest_lo} <= a_in & m_in;
            {rsp.found_mask_hi, rsp.found_mask_lo} <= m_in;
            rsp.found_gw_present <= r.gw_present;
            {rsp.found_gw_hi, rsp.found_gw_lo} <= g_in;
            rsp.found_iface <= 8'(iface_k);
            rsp.found_metric <= r.route_metric;
            rsp.found_origin <= r.route_origin;
          end
        end
        OP_REMOVE: begin
          rsp.slot_out <= r.slot_in;
          rsp.status <= slot_ok ? ST_OK : ST_BAD_SLOT;
        end
        OP_LOOK_V4, OP_LOOK_V6: begin
          if (!have) rsp.status <= ST_NO_MATCH;
          else begin
            rsp.status <= ST_OK;
            rsp.slot_out <= 4'(best);
            {rsp.dest_hi, rsp.dest_lo} <= e_dest;
            {rsp.found_mask_hi, rsp.found_mask_lo} <= e_mask;
            rsp.found_gw_present <= e_gwp;
            {rsp.found_gw_hi, rsp.found_gw_lo} <= e_gw;
            rsp.found_iface <= 8'(e_iface);
            rsp.found_metric <= e_metric;
            rsp.found_origin <= e_origin;
          end
        end
        default: rsp.status <= ST_BAD_SLOT;
      endcase
    end
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (cmd.do_add && have_free) begin
        valid[free_slot] <= 1'b1;
        count <= count + 1'b1;
      end
      if (cmd.do_remove && slot_ok) begin
        valid[tgt] <= 1'b0;
        count <= count - 1'b1;
      end
    end
  end
endmodule

/* hdl/lrt_ctrl.sv */
// ----------------------------------------------------------------------------
// lrt_ctrl
// Sequencer: accept, scan/fix-up, winner re-read, result hand-off.
// ----------------------------------------------------------------------------
module lrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  lrt_pkg::sts_t sts,
  output lrt_pkg::cmd_t cmd,
  output logic          reread
);
  import lrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;
  logic       hold;  // result waiting at output

  logic out_free;
  assign out_free = !hold || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign out_valid = hold;

  always_comb begin
    cmd = '0;
    reread = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load_req = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        case (sts.opcode)
          OP_REMOVE, OP_LOOK_V4, OP_LOOK_V6: state_next = S_SCAN;
          default: state_next = S_EMIT;
        endcase
      end
      S_SCAN: begin
        if (sts.opcode == OP_REMOVE) cmd.rank_step = 1'b1;
        else cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = (sts.opcode == OP_REMOVE) ? S_EMIT : S_FETCH;
      end
      S_FETCH: begin
        reread = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_EMIT;
      S_EMIT: if (out_free) begin
        cmd.emit = 1'b1;
        cmd.do_add = (sts.opcode == OP_ADD_V4) || (sts.opcode == OP_ADD_V6);
        cmd.do_remove = (sts.opcode == OP_REMOVE);
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hold <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) hold <= 1'b1;
      else if (!out_stall) hold <= 1'b0;
    end
  end
endmodule

/* hdl/lpm_route_table_core.sv */
// ----------------------------------------------------------------------------
// lpm_route_table_core
// Longest-prefix-match IPv4/IPv6 route table with add, remove and lookup.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  req     | req_valid/req_stall| lrt_pkg::req_t
//  rsp     | rsp_valid/rsp_stall| lrt_pkg::rsp_t
//
// Add: the free slot is found by a priority encoder, without a scan.
// Remove: the rank fix-up walks one entry a cycle.
// Lookup: one RAM read port scans an entry a cycle,
// then the winner's address is loaded and its entry read again.
// One transaction in flight at a time; the next request can be accepted in
// the cycle after the result register has been loaded.
// Reset (rst, synchronous) clears the valid bits, route count and control.
// A stalled result holds in the output register; the next result waits to emit.
module lpm_route_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int IFACE_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic reread;

  lrt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_stall(req_stall),
    .out_valid(rsp_valid), .out_stall(rsp_stall),
    .sts(sts), .cmd(cmd), .reread(reread)
  );

  // Winner re-read: the datapath points the RAM read address at the best entry.
  lrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .IFACE_ID_BITS(IFACE_ID_BITS)) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .reread(reread), .sts(sts),
    .rsp(rsp)
  );
endmodule

/* hdl/lrt_checker.sv */
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks of the route table handshake and result codes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lrt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp dropped")
  `ASSERT_IMPL(a_full_zero, clk, rst, rsp_valid && rsp.status == ST_FULL, rsp.slot_out == 4'd0, "full slot")
  `ASSERT_IMPL(a_miss_zero, clk, rst, rsp_valid && rsp.status == ST_NO_MATCH, rsp.found_metric == 32'd0 && rsp.slot_out == 4'd0, "miss fields")
  `ASSERT_NEXT(a_busy, clk, rst, req_valid && !req_stall, req_stall, "accept while busy")
endmodule

bind lpm_route_table_core lrt_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
